FILE: hdl/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg
// Shared sizes, codes and types of the color sample collector.
// ----------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

   // Number of entries in the sample table
   localparam int SAMPLE_DEPTH = 256;

   localparam int IDX_W       = $clog2(SAMPLE_DEPTH);
   localparam int CNT_W       = $clog2(SAMPLE_DEPTH + 1);
   localparam int CHAN_W      = 8;
   localparam int NUM_CHAN    = 3;
   localparam int CHAN_SEL_W  = 2;
   localparam int KEY_W       = NUM_CHAN * CHAN_W;
   localparam int TOT_W       = CHAN_W + CNT_W;
   localparam int BRIGHT_W    = 10;
   localparam int COUNT_OUT_W = 9;

   // Operation codes
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

FILE: hdl/csc_divider.sv
// ----------------------------------------------------------------------------
// csc_divider
// Restoring divider, one quotient bit per cycle, for the channel means.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_divider (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [csc_pkg::TOT_W-1:0]  dividend,
   input  wire logic [csc_pkg::CNT_W-1:0]  divisor,
   output csc_pkg::div_status_type         status,
   output logic      [csc_pkg::TOT_W-1:0]  quotient
);

   localparam int STEP_W = $clog2(csc_pkg::TOT_W + 1);

   logic                        busy_ff;
   logic                        done_ff;
   logic [STEP_W-1:0]           step_ff;
   logic [csc_pkg::CNT_W-1:0]   rem_ff;
   logic [csc_pkg::TOT_W-1:0]   quo_ff;

   logic [csc_pkg::CNT_W:0]     shifted;
   logic                        take;
   logic [csc_pkg::CNT_W-1:0]   rem_in;

   // Shift in the next dividend bit, subtract when it fits
   always_comb begin
      shifted = {rem_ff, quo_ff[csc_pkg::TOT_W-1]};
      take    = (shifted >= {1'b0, divisor});
      if (take) begin
         rem_in = csc_pkg::CNT_W'(shifted - {1'b0, divisor});
      end else begin
         rem_in = shifted[csc_pkg::CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (step_ff == STEP_W'(1))) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         step_ff <= STEP_W'(csc_pkg::TOT_W);
         rem_ff  <= '0;
         quo_ff  <= dividend;
      end else if (busy_ff) begin
         step_ff <= step_ff - STEP_W'(1);
         rem_ff  <= rem_in;
         quo_ff  <= {quo_ff[csc_pkg::TOT_W-2:0], take};
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

`default_nettype wire

FILE: hdl/color_sample_collector.sv
// ----------------------------------------------------------------------------
// color_sample_collector
// Keeps a table of distinct RGB samples with count, brightness range and
// per-channel means.
// ----------------------------------------------------------------------------
// Sequence: a clear goes straight to the response; an add searches the n stored
// entries at one read per cycle from the table memory, and a new sample is
// then written and followed by three serial divides, one per channel mean.
// Throughput: one transaction at a time; the next is accepted as soon as
// the result is registered, even while the consumer has not taken it.
// Reset clears count and statistics; table contents stay undefined.
`default_nettype none

module color_sample_collector (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_red,
   input  wire logic [7:0]  req_green,
   input  wire logic [7:0]  req_blue,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [8:0]       rsp_sample_count,
   output logic [9:0]       rsp_min_brightness,
   output logic [9:0]       rsp_max_brightness,
   output logic [7:0]       rsp_mean_red,
   output logic [7:0]       rsp_mean_green,
   output logic [7:0]       rsp_mean_blue,
   output logic             rsp_was_duplicate,
   output logic             rsp_table_full
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_WRITE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_RESPOND
   } state_type;

   // ------------------------------------------------------------------
   // Registers and their next values
   // ------------------------------------------------------------------
   state_type                         state_ff,      state_in;
   logic [csc_pkg::KEY_W-1:0]         key_ff,        key_in;
   logic [csc_pkg::CNT_W-1:0]         issue_idx_ff,  issue_idx_in;
   logic                              rd_vld_ff,     rd_vld_in;
   logic [csc_pkg::CNT_W-1:0]         count_ff,      count_in;
   logic [csc_pkg::BRIGHT_W-1:0]      low_ff,        low_in;
   logic [csc_pkg::BRIGHT_W-1:0]      high_ff,       high_in;
   logic [csc_pkg::TOT_W-1:0]         total_ff [csc_pkg::NUM_CHAN];
   logic [csc_pkg::TOT_W-1:0]         total_in [csc_pkg::NUM_CHAN];
   logic [csc_pkg::CHAN_W-1:0]        mean_ff  [csc_pkg::NUM_CHAN];
   logic [csc_pkg::CHAN_W-1:0]        mean_in  [csc_pkg::NUM_CHAN];
   logic                              dup_ff,        dup_in;
   logic                              full_ff,       full_in;
   logic [csc_pkg::CHAN_SEL_W-1:0]    lane_ff,       lane_in;

   logic                              rsp_valid_ff,  rsp_valid_in;
   logic [csc_pkg::COUNT_OUT_W-1:0]   rsp_count_ff,  rsp_count_in;
   logic [csc_pkg::BRIGHT_W-1:0]      rsp_min_ff,    rsp_min_in;
   logic [csc_pkg::BRIGHT_W-1:0]      rsp_max_ff,    rsp_max_in;
   logic [csc_pkg::CHAN_W-1:0]        rsp_mean_ff [csc_pkg::NUM_CHAN];
   logic [csc_pkg::CHAN_W-1:0]        rsp_mean_in [csc_pkg::NUM_CHAN];
   logic                              rsp_dup_ff,    rsp_dup_in;
   logic                              rsp_full_ff,   rsp_full_in;

   // Sample table memory, one write and one registered read per cycle
   logic [csc_pkg::KEY_W-1:0]         sample_mem [csc_pkg::SAMPLE_DEPTH];
   logic [csc_pkg::KEY_W-1:0]         mem_rdata_ff;
   logic                              mem_we;

   logic [csc_pkg::BRIGHT_W-1:0]      bright;
   logic                              hit;

   // Shared mean divider
   logic                              div_start;
   csc_pkg::div_status_type           div_status;
   logic [csc_pkg::TOT_W-1:0]         div_quotient;

   csc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total_ff[lane_ff]),
      .divisor  (count_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign div_start = (state_ff == ST_DIV_START);
   assign mem_we    = (state_ff == ST_WRITE);
   assign hit       = rd_vld_ff && (mem_rdata_ff == key_ff);

   // Brightness of the pending sample
   assign bright = csc_pkg::BRIGHT_W'(key_ff[23:16])
                 + csc_pkg::BRIGHT_W'(key_ff[15:8])
                 + csc_pkg::BRIGHT_W'(key_ff[7:0]);

   // ------------------------------------------------------------------
   // Table memory: write a new sample at the fill position, read the
   // search address every cycle
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_mem[count_ff[csc_pkg::IDX_W-1:0]] <= key_ff;
      end
      mem_rdata_ff <= sample_mem[issue_idx_ff[csc_pkg::IDX_W-1:0]];
   end

   // ------------------------------------------------------------------
   // Next-state logic
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      issue_idx_in = issue_idx_ff;
      rd_vld_in    = 1'b0;
      count_in     = count_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      total_in     = total_ff;
      mean_in      = mean_ff;
      dup_in       = dup_ff;
      full_in      = full_ff;
      lane_in      = lane_ff;

      // Drop the result valid once the consumer takes the transaction
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_dup_in   = rsp_dup_ff;
      rsp_full_in  = rsp_full_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == csc_pkg::OP_CLEAR) begin
                  // Empty the table by count; stale entries are never read
                  count_in = '0;
                  low_in   = '0;
                  high_in  = '0;
                  for (int c = 0; c < csc_pkg::NUM_CHAN; c++) begin
                     total_in[c] = '0;
                     mean_in[c]  = '0;
                  end
                  dup_in   = 1'b0;
                  full_in  = 1'b0;
                  state_in = ST_RESPOND;
               end else begin
                  key_in       = {req_red, req_green, req_blue};
                  issue_idx_in = '0;
                  state_in     = ST_SEARCH;
               end
            end
         end

         ST_SEARCH: begin
            // Reads are pipelined: compare the entry fetched last cycle
            // while issuing the next address
            if (hit) begin
               dup_in   = 1'b1;
               full_in  = 1'b0;
               state_in = ST_RESPOND;
            end else if ((issue_idx_ff == count_ff) && !rd_vld_ff) begin
               dup_in = 1'b0;
               if (count_ff == csc_pkg::CNT_W'(csc_pkg::SAMPLE_DEPTH)) begin
                  full_in  = 1'b1;
                  state_in = ST_RESPOND;
               end else begin
                  full_in  = 1'b0;
                  state_in = ST_WRITE;
               end
            end else if (issue_idx_ff != count_ff) begin
               rd_vld_in    = 1'b1;
               issue_idx_in = issue_idx_ff + csc_pkg::CNT_W'(1);
            end
         end

         ST_WRITE: begin
            if (count_ff == '0) begin
               low_in  = bright;
               high_in = bright;
            end else begin
               if (bright < low_ff) begin
                  low_in = bright;
               end
               if (bright > high_ff) begin
                  high_in = bright;
               end
            end
            count_in    = count_ff + csc_pkg::CNT_W'(1);
            total_in[0] = total_ff[0] + csc_pkg::TOT_W'(key_ff[23:16]);
            total_in[1] = total_ff[1] + csc_pkg::TOT_W'(key_ff[15:8]);
            total_in[2] = total_ff[2] + csc_pkg::TOT_W'(key_ff[7:0]);
            lane_in     = '0;
            state_in    = ST_DIV_START;
         end

         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end

         ST_DIV_WAIT: begin
            if (div_status.done) begin
               // Mean never exceeds a channel value, so the low bits hold it
               mean_in[lane_ff] = div_quotient[csc_pkg::CHAN_W-1:0];
               if (lane_ff == csc_pkg::CHAN_SEL_W'(csc_pkg::NUM_CHAN - 1)) begin
                  state_in = ST_RESPOND;
               end else begin
                  lane_in  = lane_ff + csc_pkg::CHAN_SEL_W'(1);
                  state_in = ST_DIV_START;
               end
            end
         end

         ST_RESPOND: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = csc_pkg::COUNT_OUT_W'(count_ff);
               rsp_min_in   = low_ff;
               rsp_max_in   = high_ff;
               rsp_mean_in  = mean_ff;
               rsp_dup_in   = dup_ff;
               rsp_full_in  = full_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // State and registered outputs
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         count_ff     <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
         for (int c = 0; c < csc_pkg::NUM_CHAN; c++) begin
            total_ff[c] <= '0;
            mean_ff[c]  <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_ff       <= key_in;
         issue_idx_ff <= issue_idx_in;
         rd_vld_ff    <= rd_vld_in;
         count_ff     <= count_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         total_ff     <= total_in;
         mean_ff      <= mean_in;
         dup_ff       <= dup_in;
         full_ff      <= full_in;
         lane_ff      <= lane_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_count_ff <= rsp_count_in;
         rsp_min_ff   <= rsp_min_in;
         rsp_max_ff   <= rsp_max_in;
         rsp_mean_ff  <= rsp_mean_in;
         rsp_dup_ff   <= rsp_dup_in;
         rsp_full_ff  <= rsp_full_in;
      end
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_count   = rsp_count_ff;
   assign rsp_min_brightness = rsp_min_ff;
   assign rsp_max_brightness = rsp_max_ff;
   assign rsp_mean_red       = rsp_mean_ff[0];
   assign rsp_mean_green     = rsp_mean_ff[1];
   assign rsp_mean_blue      = rsp_mean_ff[2];
   assign rsp_was_duplicate  = rsp_dup_ff;
   assign rsp_table_full     = rsp_full_ff;

`ifndef ASSERT_OFF
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= csc_pkg::CNT_W'(csc_pkg::SAMPLE_DEPTH))
      else $error("sample count exceeds table depth");

   a_range_ordered: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (low_ff <= high_ff))
      else $error("min brightness above max brightness");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_dup_ff && rsp_full_ff))
      else $error("duplicate and full flagged together");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_count_ff == '0)) |->
         ((rsp_max_ff == '0) && (rsp_mean_ff[0] == '0) && (rsp_mean_ff[2] == '0)))
      else $error("empty table reports nonzero statistics");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_op == csc_pkg::OP_CLEAR)) |=> (count_ff == '0))
      else $error("clear did not empty the table");

   a_div_only_waiting: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> (state_ff == ST_DIV_WAIT))
      else $error("divider busy outside its wait state");
`endif

endmodule

`default_nettype wire
